/* src/lkvc_pkg.sv */
// Shared constants and controller/datapath interface types for the LRU key/value cache.
// No dependencies; used by every module of the block.
package lkvc_pkg;

	// Default entry count and fixed field widths
	localparam int CAPACITY_DEF = 16;
	localparam int CFG_W        = 5;
	localparam int KEY_W        = 16;
	localparam int VAL_W        = 32;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	// Register map
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
	localparam logic             REG_CAPACITY = 1'b0;   // paddr[2] selects the register

	// Operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;   // latch the item, clear scan results, rewind the address
		logic scan_rd;   // read one entry for the lookup pass
		logic decide;    // settle target slot and eviction, rewind the address
		logic upd_rd;    // read one rank for the update pass
		logic commit;    // write key/value and valid bits
		logic respond;   // present the get result
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic addr_last;
		logic found;
		logic is_put;
	} stat_t;

endpackage

/* src/lru_key_value_cache_top.sv */
// A get that misses walks the entries once (scan, flush, decide) and raises done as busy falls; a hit
// or a put walks them twice (adding update, flush and commit), a hit raising done likewise.
// Throughput is one item per busy period: one or two sequential passes over the entry stores, one
// entry per cycle through the single store read port, set its length. The receiver cannot stall.
// Reset invalidates all entries, clears the control state and sets the capacity register to 16.
// Top level: APB register, controller and datapath; depends on lkvc_pkg, lkvc_ctrl, lkvc_dpath.
module lru_key_value_cache_top #(
	parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [lkvc_pkg::KEY_W-1:0]    key,
	input  logic [lkvc_pkg::VAL_W-1:0]    value,
	output logic                          done,
	output logic                          hit,
	output logic [lkvc_pkg::VAL_W-1:0]    read_value,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lkvc_pkg::APB_AW-1:0]   paddr,
	input  logic [lkvc_pkg::APB_DW-1:0]   pwdata,
	output logic [lkvc_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	logic [lkvc_pkg::CFG_W-1:0] cap_q;
	lkvc_pkg::cmd_t             cmd;
	lkvc_pkg::stat_t            stat;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == lkvc_pkg::REG_CAPACITY) begin
			cap_q <= pwdata[lkvc_pkg::CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == lkvc_pkg::REG_CAPACITY)
	                ? lkvc_pkg::APB_DW'(cap_q) : '0;

	lkvc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lkvc_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cap_cfg    (cap_q),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.done       (done),
		.hit        (hit),
		.read_value (read_value)
	);

	// A result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// Results never come in consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A miss returns a zero value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (read_value == '0))
		else $error("miss returned a non-zero value");

endmodule

/* src/lkvc_ctrl.sv */
// Sequencing state machine for the LRU key/value cache.
// Depends on lkvc_pkg for the command and status structs.
module lkvc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lkvc_pkg::stat_t stat,
	output lkvc_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_SFLUSH = 7'b0000100,
		ST_DECIDE = 7'b0001000,
		ST_UPDATE = 7'b0010000,
		ST_UFLUSH = 7'b0100000,
		ST_COMMIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.addr_last) state_d = ST_SFLUSH;
			end
			ST_SFLUSH: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (!stat.is_put && !stat.found) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.upd_rd = 1'b1;
				if (stat.addr_last) state_d = ST_UFLUSH;
			end
			ST_UFLUSH: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit  = 1'b1;
				cmd.respond = !stat.is_put;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* src/lkvc_dpath.sv */
// Entry stores, lookup accumulators and rank update for the LRU key/value cache.
// Depends on lkvc_pkg for widths and the command and status structs.
module lkvc_dpath #(
	parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lkvc_pkg::cmd_t               cmd,
	output lkvc_pkg::stat_t              stat,
	input  logic [lkvc_pkg::CFG_W-1:0]   cap_cfg,
	input  logic                         operation,
	input  logic [lkvc_pkg::KEY_W-1:0]   key,
	input  logic [lkvc_pkg::VAL_W-1:0]   value,
	output logic                         done,
	output logic                         hit,
	output logic [lkvc_pkg::VAL_W-1:0]   read_value
);

	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CNTW > lkvc_pkg::CFG_W) ? CNTW : lkvc_pkg::CFG_W;

	// Entry stores
	logic [lkvc_pkg::KEY_W-1:0] key_mem  [CAPACITY];
	logic [lkvc_pkg::VAL_W-1:0] val_mem  [CAPACITY];
	logic [IW-1:0]              rank_mem [CAPACITY];
	logic [CAPACITY-1:0]        valid_q;

	// Item and walk control
	logic                       op_q;
	logic [lkvc_pkg::KEY_W-1:0] key_q;
	logic [lkvc_pkg::VAL_W-1:0] val_q;
	logic [IW-1:0]              addr_q;

	// Read stage
	logic                       scan_s1, upd_s1;
	logic [IW-1:0]              idx_s1;
	logic [lkvc_pkg::KEY_W-1:0] key_rd_s1;
	logic [lkvc_pkg::VAL_W-1:0] val_rd_s1;
	logic [IW-1:0]              rank_rd_s1;
	logic                       vld_rd;

	// Lookup results
	logic                       found_q, have_vic_q, have_free_q, evict_q;
	logic [IW-1:0]              match_idx_q, match_rank_q, vic_idx_q, vic_rank_q;
	logic [IW-1:0]              free_idx_q, target_q;
	logic [lkvc_pkg::VAL_W-1:0] match_val_q;
	logic [CNTW-1:0]            count_q;

	// Decision and rank update logic
	logic [CMPW-1:0]            cap_eff, count_ext;
	logic                       evict_d;
	logic [IW-1:0]              target_d, rank_new;

	// Output registers
	logic                       done_q, hit_q;
	logic [lkvc_pkg::VAL_W-1:0] rdval_q;

	assign vld_rd = valid_q[idx_s1];

	// Latch the item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			key_q <= key;
			val_q <= value;
		end
	end

	// Walk the entries, rewinding at the start of each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.capture || cmd.decide) begin
			addr_q <= '0;
		end else if (cmd.scan_rd || cmd.upd_rd) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// Read the stores at the walk address
	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.upd_rd) begin
			key_rd_s1  <= key_mem[addr_q];
			val_rd_s1  <= val_mem[addr_q];
			rank_rd_s1 <= rank_mem[addr_q];
			idx_s1     <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			upd_s1  <= cmd.upd_rd;
		end
	end

	// Accumulate match, occupancy, oldest entry and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			have_vic_q  <= 1'b0;
			have_free_q <= 1'b0;
			count_q     <= '0;
		end else if (cmd.capture) begin
			found_q     <= 1'b0;
			have_vic_q  <= 1'b0;
			have_free_q <= 1'b0;
			count_q     <= '0;
		end else if (scan_s1) begin
			if (vld_rd) begin
				count_q <= count_q + 1'b1;
				if (key_rd_s1 == key_q) found_q <= 1'b1;
				if (!have_vic_q || rank_rd_s1 > vic_rank_q) have_vic_q <= 1'b1;
			end else if (!have_free_q) begin
				have_free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (vld_rd) begin
				if (key_rd_s1 == key_q) begin
					match_idx_q  <= idx_s1;
					match_rank_q <= rank_rd_s1;
					match_val_q  <= val_rd_s1;
				end
				if (!have_vic_q || rank_rd_s1 > vic_rank_q) begin
					vic_idx_q  <= idx_s1;
					vic_rank_q <= rank_rd_s1;
				end
			end else if (!have_free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// Settle eviction and the slot to write
	always_comb begin
		cap_eff = CMPW'(cap_cfg);
		if (cap_eff == '0) cap_eff = CMPW'(1);
		if (cap_eff > CMPW'(CAPACITY)) cap_eff = CMPW'(CAPACITY);
		count_ext = CMPW'(count_q);
		evict_d   = !found_q && op_q && (count_ext >= cap_eff);
		if (found_q) begin
			target_d = match_idx_q;
		end else if (evict_d && (!have_free_q || vic_idx_q < free_idx_q)) begin
			target_d = vic_idx_q;
		end else begin
			target_d = free_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evict_q <= 1'b0;
		end else if (cmd.capture) begin
			evict_q <= 1'b0;
		end else if (cmd.decide) begin
			evict_q <= evict_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) target_q <= target_d;
	end

	// Age entries more recent than the touched one, or all on insertion
	always_comb begin
		if (idx_s1 == target_q) begin
			rank_new = '0;
		end else if (vld_rd && (!found_q || rank_rd_s1 < match_rank_q)) begin
			rank_new = rank_rd_s1 + 1'b1;
		end else begin
			rank_new = rank_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_s1) rank_mem[idx_s1] <= rank_new;
	end

	// Write key and value on a put
	always_ff @(posedge clk) begin
		if (cmd.commit && op_q) begin
			key_mem[target_q] <= key_q;
			val_mem[target_q] <= val_q;
		end
	end

	// Drop the evicted entry, mark the written one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (evict_q) valid_q[vic_idx_q] <= 1'b0;
			if (op_q)    valid_q[target_q]  <= 1'b1;
		end
	end

	// Present the get result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			hit_q   <= found_q;
			rdval_q <= found_q ? match_val_q : '0;
		end
	end

	assign stat.addr_last = (addr_q == IW'(CAPACITY - 1));
	assign stat.found     = found_q;
	assign stat.is_put    = op_q;
	assign done           = done_q;
	assign hit            = hit_q;
	assign read_value     = rdval_q;

endmodule
